### rtl/core/pcmffc_pkg.sv
// Shared types, constants and helpers for the PCM frame format converter.
`timescale 1ns / 1ps

package pcmffc_pkg;

  localparam int MAX_FACTOR   = 8;
  localparam int RESULT_LIMIT = 8;
  localparam int REP_MAX      = (MAX_FACTOR < RESULT_LIMIT) ? MAX_FACTOR : RESULT_LIMIT;
  localparam int FACTOR_W     = 4;
  localparam int PHASE_W      = (MAX_FACTOR > 2) ? $clog2(MAX_FACTOR) : 1;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [7:0] BYTE_MASK = 8'hff;
  localparam logic [7:0] BYTE_BIAS = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_STEREO       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BYTE_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STEREO       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BYTE_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FACTOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATE_FACTOR  = 3'd5;

  typedef struct packed {
    logic                src_stereo;
    logic                src_byte_samples;
    logic                dst_stereo;
    logic                dst_byte_samples;
    logic [FACTOR_W-1:0] repeat_factor;
    logic [FACTOR_W-1:0] decimate_factor;
  } cfg_t;

  typedef struct packed {
    logic                seg_start;
    logic [SAMPLE_W-1:0] in_left;
    logic [SAMPLE_W-1:0] in_right;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_left;
    logic [SAMPLE_W-1:0] out_right;
    logic                last_of_run;
  } out_item_t;

  // Zero reads as one, anything above hi saturates to hi.
  function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f,
                                                        input int hi);
    logic [FACTOR_W-1:0] res;
    res = f;
    if (f == '0) begin
      res = FACTOR_W'(1);
    end else if (int'(f) > hi) begin
      res = FACTOR_W'(hi);
    end
    return res;
  endfunction

  // Signed 16-bit sample to destination encoding.
  function automatic logic [SAMPLE_W-1:0] narrow(input logic [SAMPLE_W-1:0] v,
                                                 input logic byte_samples);
    logic [SAMPLE_W-1:0] res;
    res = v;
    if (byte_samples) begin
      res = {8'h00, (v[15:8] ^ BYTE_BIAS) & BYTE_MASK};
    end
    return res;
  endfunction

endpackage

### rtl/core/pcm_frame_format_converter.sv
// Top level of the PCM frame format converter: config, decimation, repeat and output stage.
// Each result passes from the input through the job register and then the output register.
// Throughput: one result per cycle while out_stall is low; an item occupies the repeat stage
// until it has emitted all its copies (1 to 8), and items dropped by decimation never enter it.
// The single-entry job register plus output register bound the overlap to one item ahead.
// Reset (synchronous, rst_n low): config returns to defaults, group phase and valids clear.
`timescale 1ns / 1ps

module pcm_frame_format_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [3:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pcmffc_pkg::in_item_t          in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pcmffc_pkg::out_item_t         out_data
);

  pcmffc_pkg::cfg_t cfg_r;

  logic [pcmffc_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic signed [15:0]                 held_left_r, held_left_nxt;
  logic signed [15:0]                 held_right_r, held_right_nxt;

  logic                               job_valid_r, job_valid_nxt;
  logic [15:0]                        job_left_r, job_left_nxt;
  logic [15:0]                        job_right_r, job_right_nxt;
  logic [pcmffc_pkg::FACTOR_W-1:0]    job_cnt_r, job_cnt_nxt;

  logic                               out_valid_r, out_valid_nxt;
  pcmffc_pkg::out_item_t              out_data_r, out_data_nxt;

  logic signed [15:0]                 conv_left;
  logic signed [15:0]                 conv_right;
  logic [pcmffc_pkg::FACTOR_W-1:0]    dec;
  logic [pcmffc_pkg::FACTOR_W-1:0]    rep;
  logic [pcmffc_pkg::PHASE_W-1:0]     phase_cur;
  logic                               group_done;
  logic signed [15:0]                 emit_left;
  logic signed [15:0]                 emit_right;
  logic                               produce;
  logic                               out_ok;
  logic                               issue;
  logic                               job_done;
  logic                               accept;

  pcmffc_convert u_convert (
    .cfg     (cfg_r),
    .item    (in_data),
    .left_w  (conv_left),
    .right_w (conv_right)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_stereo       <= 1'b0;
      cfg_r.src_byte_samples <= 1'b1;
      cfg_r.dst_stereo       <= 1'b0;
      cfg_r.dst_byte_samples <= 1'b1;
      cfg_r.repeat_factor    <= pcmffc_pkg::FACTOR_W'(1);
      cfg_r.decimate_factor  <= pcmffc_pkg::FACTOR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcmffc_pkg::REG_SRC_STEREO:       cfg_r.src_stereo       <= cfg_wdata[0];
        pcmffc_pkg::REG_SRC_BYTE_SAMPLES: cfg_r.src_byte_samples <= cfg_wdata[0];
        pcmffc_pkg::REG_DST_STEREO:       cfg_r.dst_stereo       <= cfg_wdata[0];
        pcmffc_pkg::REG_DST_BYTE_SAMPLES: cfg_r.dst_byte_samples <= cfg_wdata[0];
        pcmffc_pkg::REG_REPEAT_FACTOR:    cfg_r.repeat_factor    <= cfg_wdata;
        pcmffc_pkg::REG_DECIMATE_FACTOR:  cfg_r.decimate_factor  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ok   = !out_valid_r || !out_stall;
  assign issue    = job_valid_r && out_ok;
  assign job_done = issue && (job_cnt_r == pcmffc_pkg::FACTOR_W'(1));
  assign in_stall = job_valid_r && !job_done;
  assign accept   = in_valid && !in_stall;

  // decimation / repeat decision for the incoming frame
  always_comb begin
    dec        = pcmffc_pkg::clamp_factor(cfg_r.decimate_factor, pcmffc_pkg::MAX_FACTOR);
    rep        = pcmffc_pkg::clamp_factor(cfg_r.repeat_factor, pcmffc_pkg::REP_MAX);
    phase_cur  = in_data.seg_start ? '0 : phase_r;
    group_done = (int'(phase_cur) + 1) >= int'(dec);
    if (phase_cur == '0) begin
      emit_left  = conv_left;
      emit_right = conv_right;
    end else begin
      emit_left  = held_left_r;
      emit_right = held_right_r;
    end

    phase_nxt      = phase_r;
    held_left_nxt  = held_left_r;
    held_right_nxt = held_right_r;
    produce        = 1'b0;
    job_left_nxt   = job_left_r;
    job_right_nxt  = job_right_r;
    job_cnt_nxt    = job_cnt_r;

    if (dec > pcmffc_pkg::FACTOR_W'(1)) begin
      if (phase_cur == '0) begin
        held_left_nxt  = conv_left;
        held_right_nxt = conv_right;
      end
      if (group_done) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_cur + pcmffc_pkg::PHASE_W'(1);
      end
      produce = group_done;
    end else begin
      phase_nxt = '0;
      produce   = 1'b1;
    end
    if (!accept) begin
      phase_nxt      = phase_r;
      held_left_nxt  = held_left_r;
      held_right_nxt = held_right_r;
    end

    job_valid_nxt = job_valid_r;
    if (accept && produce) begin
      job_valid_nxt = 1'b1;
      if (dec > pcmffc_pkg::FACTOR_W'(1)) begin
        job_left_nxt  = pcmffc_pkg::narrow(emit_left, cfg_r.dst_byte_samples);
        job_right_nxt = cfg_r.dst_stereo ?
                        pcmffc_pkg::narrow(emit_right, cfg_r.dst_byte_samples) : 16'd0;
        job_cnt_nxt   = pcmffc_pkg::FACTOR_W'(1);
      end else begin
        job_left_nxt  = pcmffc_pkg::narrow(conv_left, cfg_r.dst_byte_samples);
        job_right_nxt = cfg_r.dst_stereo ?
                        pcmffc_pkg::narrow(conv_right, cfg_r.dst_byte_samples) : 16'd0;
        job_cnt_nxt   = rep;
      end
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (issue) begin
      job_cnt_nxt = job_cnt_r - pcmffc_pkg::FACTOR_W'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (issue) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_left    = job_left_r;
      out_data_nxt.out_right   = job_right_r;
      out_data_nxt.last_of_run = (job_cnt_r == pcmffc_pkg::FACTOR_W'(1));
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      held_left_r  <= '0;
      held_right_r <= '0;
      job_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_left_r  <= held_left_nxt;
      held_right_r <= held_right_nxt;
      job_valid_r  <= job_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_left_r  <= job_left_nxt;
    job_right_r <= job_right_nxt;
    job_cnt_r   <= job_cnt_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_job_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (job_cnt_r != '0))
    else $error("pending job with zero copies left");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> job_valid_r)
    else $error("input stalled with no job pending");

  a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && (job_cnt_r != pcmffc_pkg::FACTOR_W'(1))) |=> job_valid_r)
    else $error("job dropped before its last copy");

  a_repeat_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (dec == pcmffc_pkg::FACTOR_W'(1))) |=> (phase_r == '0))
    else $error("group phase not cleared outside decimation");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && (job_cnt_r == pcmffc_pkg::FACTOR_W'(1))) |=> out_data_r.last_of_run)
    else $error("final copy not marked last");

endmodule

### rtl/core/pcmffc_convert.sv
// Source sample widening and channel mixing to signed 16-bit left/right.
`timescale 1ns / 1ps

module pcmffc_convert (
  input  pcmffc_pkg::cfg_t       cfg,
  input  pcmffc_pkg::in_item_t   item,
  output logic signed [15:0]     left_w,
  output logic signed [15:0]     right_w
);

  logic signed [15:0] l_wide;
  logic signed [15:0] r_wide;
  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;

  always_comb begin
    if (cfg.src_byte_samples) begin
      l_wide = {item.in_left[7:0] ^ pcmffc_pkg::BYTE_BIAS, 8'h00};
      r_wide = {item.in_right[7:0] ^ pcmffc_pkg::BYTE_BIAS, 8'h00};
    end else begin
      l_wide = item.in_left;
      r_wide = item.in_right;
    end
    if (!cfg.src_stereo) begin
      r_wide = l_wide;
    end
    sum     = {l_wide[15], l_wide} + {r_wide[15], r_wide};
    // round toward zero: bias odd negative sums up before the shift
    sum_adj = sum + {16'd0, sum[16] & sum[0]};
    right_w = r_wide;
    if (cfg.src_stereo && !cfg.dst_stereo) begin
      left_w = sum_adj[16:1];
    end else begin
      left_w = l_wide;
    end
  end

endmodule
